// ----- hw/rtl/qsw_pkg.sv -----
`default_nettype none

package qsw_pkg;

  localparam int FracBits = 15;
  localparam int OneVal   = 1 << FracBits;
  localparam int HalfVal  = 1 << (FracBits - 1);

  localparam int SmpW   = 16;  // sine / cosine input samples
  localparam int ModeW  = 5;
  localparam int OutW   = 18;  // shaped output sample
  localparam int TermW  = 18;  // sin2x, cos2x, scaled term
  localparam int Sin4W  = 20;  // sin4x
  localparam int WorkW  = 22;  // rule arithmetic before saturation
  localparam int ScaleW = 17;  // 0.85 in Q0.16 as a positive signed operand

  localparam logic [ScaleW-1:0] Scale085 = ScaleW'(55706);

  localparam int OutMax = (1 << (OutW - 1)) - 1;
  localparam int OutMin = -(1 << (OutW - 1));

  // shape rules
  localparam logic [ModeW-1:0] ModeSine        = 5'd0;
  localparam logic [ModeW-1:0] ModeFoldFull    = 5'd1;
  localparam logic [ModeW-1:0] ModeHalfWave    = 5'd2;
  localparam logic [ModeW-1:0] ModeHalfFold    = 5'd3;
  localparam logic [ModeW-1:0] ModeHalfSin2x   = 5'd4;
  localparam logic [ModeW-1:0] ModeOctFold     = 5'd5;
  localparam logic [ModeW-1:0] ModeAbsSin2x    = 5'd6;
  localparam logic [ModeW-1:0] ModeOctFoldAbs  = 5'd7;
  localparam logic [ModeW-1:0] ModeHalfWaveDbl = 5'd8;
  localparam logic [ModeW-1:0] ModeEvenQuad    = 5'd9;
  localparam logic [ModeW-1:0] ModeOddQuad     = 5'd10;
  localparam logic [ModeW-1:0] ModeHalfFoldDbl = 5'd11;
  localparam logic [ModeW-1:0] ModeSin2xFlip   = 5'd12;
  localparam logic [ModeW-1:0] ModeSin2xOdd    = 5'd13;
  localparam logic [ModeW-1:0] ModeAbsCos2x    = 5'd14;
  localparam logic [ModeW-1:0] ModeRampSine    = 5'd15;
  localparam logic [ModeW-1:0] ModeRampCos     = 5'd16;
  localparam logic [ModeW-1:0] ModeScaled      = 5'd17;
  localparam logic [ModeW-1:0] ModeMixCos      = 5'd18;
  localparam logic [ModeW-1:0] ModeMixSin4x    = 5'd19;
  localparam logic [ModeW-1:0] ModeSquareEven  = 5'd20;
  localparam logic [ModeW-1:0] ModeSquareOdd   = 5'd21;
  localparam logic [ModeW-1:0] ModeCutMid      = 5'd22;
  localparam logic [ModeW-1:0] ModeCutEdge     = 5'd23;

  typedef enum logic [1:0] {
    QuadOne,
    QuadTwo,
    QuadThree,
    QuadFour
  } quad_e;

  typedef logic signed [WorkW-1:0] work_t;

  typedef struct packed {
    quad_e                   quad;
    logic signed [SmpW-1:0]  s;
    logic signed [SmpW-1:0]  c;
    logic signed [TermW-1:0] sin2x;
    logic signed [TermW-1:0] cos2x;
    logic signed [Sin4W-1:0] sin4x;
    logic signed [TermW-1:0] scaled;
  } terms_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qsw_if.sv -----
`default_nettype none

interface qsw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qsw_pkg::ModeW-1:0]    shape_mode;
  modport source (output valid, output shape_mode, input ready);
  modport sink   (input valid, input shape_mode, output ready);
endinterface

interface qsw_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [qsw_pkg::SmpW-1:0]  sine_in;
  logic signed [qsw_pkg::SmpW-1:0]  cosine_in;
  modport source (output valid, output sine_in, output cosine_in, input ready);
  modport sink   (input valid, input sine_in, input cosine_in, output ready);
endinterface

interface qsw_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [qsw_pkg::OutW-1:0]  shaped_out;
  modport source (output valid, output shaped_out, input ready);
  modport sink   (input valid, input shaped_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/quadrant_sine_waveshaper.sv -----
// Quadrant sine waveshaper.
// in_i carries one sine/cosine pair (Q1.15) per transaction; out_o returns
// one shaped, saturated 18-bit sample per input, in order. cfg_i writes the
// 5-bit shape_mode; it is always ready and should only be written while no
// item is in flight. The mode is sampled with each input item.
// Pipeline: four register stages (products, rounding, sin4x product,
// rule select + saturate). An accepted item moves through these stages in
// order and is presented on out_o from the last. One item per cycle is taken
// and delivered as long as the receiver keeps out_o.ready high; every stage,
// the multipliers included, takes a new item in each cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; bubbles are not squeezed out, nothing is lost.
// Reset clears all valid bits and sets shape_mode to 0 (sine pass-through).
`default_nettype none

module quadrant_sine_waveshaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsw_cfg_if.sink    cfg_i,
  qsw_in_if.sink     in_i,
  qsw_out_if.source  out_o
);

  localparam int ProdW  = 2 * qsw_pkg::SmpW;
  localparam int RndW   = ProdW + 2;
  localparam int KW     = qsw_pkg::ScaleW + qsw_pkg::ScaleW;
  localparam int P3W    = 2 * qsw_pkg::TermW;
  localparam int Rnd3W  = P3W + 2;
  localparam int FB     = qsw_pkg::FracBits;

  logic adv;
  logic [qsw_pkg::ModeW-1:0] mode_q;

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic signed [qsw_pkg::SmpW-1:0] s1_q, c1_q;
  logic [qsw_pkg::ModeW-1:0]       mode1_q;
  qsw_pkg::quad_e                  quad1_q, quad_d;
  logic signed [ProdW-1:0]         sc1_q, ss1_q;
  logic signed [KW-1:0]            k1_q;
  logic signed [qsw_pkg::ScaleW-1:0] pre_d, s17;

  // stage 2
  logic signed [qsw_pkg::SmpW-1:0]  s2_q, c2_q;
  logic [qsw_pkg::ModeW-1:0]        mode2_q;
  qsw_pkg::quad_e                   quad2_q;
  logic signed [qsw_pkg::TermW-1:0] sin2x_q, cos2x_q, scaled2_q;
  logic signed [qsw_pkg::TermW-1:0] sin2x_d, cos2x_d, scaled_d, sq_d;
  logic signed [RndW-1:0]           sc_rnd, ss_rnd;
  logic signed [KW-1:0]             k_rnd;

  // stage 3
  logic signed [qsw_pkg::SmpW-1:0]  s3_q, c3_q;
  logic [qsw_pkg::ModeW-1:0]        mode3_q;
  qsw_pkg::quad_e                   quad3_q;
  logic signed [qsw_pkg::TermW-1:0] sin2x3_q, cos2x3_q, scaled3_q;
  logic signed [P3W-1:0]            p3_q;

  // stage 4
  logic signed [Rnd3W-1:0]          p3_rnd;
  qsw_pkg::terms_t                  terms;
  logic signed [qsw_pkg::OutW-1:0]  shaped_d, shaped_q;

  assign adv         = !v4_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = v4_q;
  assign out_o.shaped_out = shaped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qsw_pkg::ModeSine;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.shape_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: quadrant, raw products, 0.85 scaling of the ramp term
  always_comb begin
    s17 = qsw_pkg::ScaleW'(in_i.sine_in);
    if (in_i.sine_in > 0) begin
      quad_d = (in_i.cosine_in > 0) ? qsw_pkg::QuadOne : qsw_pkg::QuadTwo;
      pre_d  = qsw_pkg::ScaleW'(qsw_pkg::OneVal) - s17;
    end else begin
      quad_d = (in_i.cosine_in < 0) ? qsw_pkg::QuadThree : qsw_pkg::QuadFour;
      pre_d  = -qsw_pkg::ScaleW'(qsw_pkg::OneVal) - s17;
    end
  end

  // stage 2: round products to nearest, ties up
  always_comb begin
    sc_rnd   = (RndW'(sc1_q) <<< 1) + RndW'(qsw_pkg::HalfVal);
    ss_rnd   = (RndW'(ss1_q) <<< 1) + RndW'(qsw_pkg::HalfVal);
    k_rnd    = k1_q + KW'(1 << 15);
    sin2x_d  = sc_rnd[FB +: qsw_pkg::TermW];
    sq_d     = ss_rnd[FB +: qsw_pkg::TermW];
    cos2x_d  = qsw_pkg::TermW'(qsw_pkg::OneVal) - sq_d;
    scaled_d = k_rnd[16 +: qsw_pkg::TermW];
  end

  // stage 4: round sin4x, then select rule
  always_comb begin
    p3_rnd       = (Rnd3W'(p3_q) <<< 1) + Rnd3W'(qsw_pkg::HalfVal);
    terms.quad   = quad3_q;
    terms.s      = s3_q;
    terms.c      = c3_q;
    terms.sin2x  = sin2x3_q;
    terms.cos2x  = cos2x3_q;
    terms.sin4x  = p3_rnd[FB +: qsw_pkg::Sin4W];
    terms.scaled = scaled3_q;
  end

  qsw_rules u_rules (
    .mode_i   (mode3_q),
    .terms_i  (terms),
    .shaped_o (shaped_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= in_i.sine_in;
      c1_q      <= in_i.cosine_in;
      mode1_q   <= mode_q;
      quad1_q   <= quad_d;
      sc1_q     <= in_i.sine_in * in_i.cosine_in;
      ss1_q     <= in_i.sine_in * in_i.sine_in;
      k1_q      <= pre_d * $signed(qsw_pkg::Scale085);

      s2_q      <= s1_q;
      c2_q      <= c1_q;
      mode2_q   <= mode1_q;
      quad2_q   <= quad1_q;
      sin2x_q   <= sin2x_d;
      cos2x_q   <= cos2x_d;
      scaled2_q <= scaled_d;

      s3_q      <= s2_q;
      c3_q      <= c2_q;
      mode3_q   <= mode2_q;
      quad3_q   <= quad2_q;
      sin2x3_q  <= sin2x_q;
      cos2x3_q  <= cos2x_q;
      scaled3_q <= scaled2_q;
      p3_q      <= sin2x_q * cos2x_q;

      shaped_q  <= shaped_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted transaction did not enter stage 1");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (v1_q == $past(v1_q)) && (v2_q == $past(v2_q)) && (v3_q == $past(v3_q)))
    else $error("pipeline moved during a stall");

  a_drain_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && adv) |=> out_o.valid)
    else $error("stage 3 item not delivered to output");

  a_cos2x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (cos2x_q >= -qsw_pkg::TermW'(qsw_pkg::OneVal)) &&
             (cos2x_q <= qsw_pkg::TermW'(qsw_pkg::OneVal)))
    else $error("cos2x out of range");

  a_sin2x_q1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && quad2_q == qsw_pkg::QuadOne) |-> (sin2x_q >= 0))
    else $error("negative sin2x in first quadrant");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/qsw_rules.sv -----
`default_nettype none

module qsw_rules (
  input  logic [qsw_pkg::ModeW-1:0]       mode_i,
  input  qsw_pkg::terms_t                 terms_i,
  output logic signed [qsw_pkg::OutW-1:0] shaped_o
);

  function automatic qsw_pkg::work_t abs_w(qsw_pkg::work_t v);
    return (v < 0) ? -v : v;
  endfunction

  qsw_pkg::work_t one, s, c, sin2x, cos2x, sin4x, scaled;
  qsw_pkg::work_t fold, half_fold, half_wave, oct_fold, p;
  logic q1, q2, q3, q4;

  always_comb begin
    one    = qsw_pkg::work_t'(qsw_pkg::OneVal);
    s      = qsw_pkg::work_t'(terms_i.s);
    c      = qsw_pkg::work_t'(terms_i.c);
    sin2x  = qsw_pkg::work_t'(terms_i.sin2x);
    cos2x  = qsw_pkg::work_t'(terms_i.cos2x);
    sin4x  = qsw_pkg::work_t'(terms_i.sin4x);
    scaled = qsw_pkg::work_t'(terms_i.scaled);

    q1 = (terms_i.quad == qsw_pkg::QuadOne);
    q2 = (terms_i.quad == qsw_pkg::QuadTwo);
    q3 = (terms_i.quad == qsw_pkg::QuadThree);
    q4 = (terms_i.quad == qsw_pkg::QuadFour);

    fold      = q1 ? one - c : q2 ? one + c : q3 ? -one - c : -one + c;
    half_fold = q1 ? one - c : q2 ? one + c : '0;
    half_wave = (q3 || q4) ? '0 : s;

    // octant fold on the doubled angle
    if (sin2x > 0) begin
      oct_fold = (cos2x > 0) ? one - cos2x : one + cos2x;
    end else begin
      oct_fold = (cos2x < 0) ? -one - cos2x : -one + cos2x;
    end

    case (mode_i)
      qsw_pkg::ModeFoldFull:    p = fold;
      qsw_pkg::ModeHalfWave:    p = half_wave;
      qsw_pkg::ModeHalfFold:    p = half_fold;
      qsw_pkg::ModeHalfSin2x:   p = (q1 || q2) ? sin2x : '0;
      qsw_pkg::ModeOctFold:     p = (q1 || q2) ? oct_fold : '0;
      qsw_pkg::ModeAbsSin2x:    p = (q1 || q2) ? abs_w(sin2x) : '0;
      qsw_pkg::ModeOctFoldAbs:  p = (q1 || q2) ? abs_w(oct_fold) : '0;
      qsw_pkg::ModeHalfWaveDbl: p = (half_wave <<< 1) - one;
      qsw_pkg::ModeEvenQuad:    p = (q1 || q3) ? '0 : s;
      qsw_pkg::ModeOddQuad:     p = (q2 || q4) ? '0 : s;
      qsw_pkg::ModeHalfFoldDbl: p = (half_fold <<< 1) - one;
      qsw_pkg::ModeSin2xFlip:   p = (q2 || q3) ? -sin2x : sin2x;
      qsw_pkg::ModeSin2xOdd:    p = q1 ? sin2x : q3 ? -sin2x : '0;
      qsw_pkg::ModeAbsCos2x:    p = (q1 || q2) ? abs_w(cos2x) : '0;
      qsw_pkg::ModeRampSine:    p = q1 ? one - s : q4 ? -one - s : '0;
      qsw_pkg::ModeRampCos:     p = q1 ? one - s : q4 ? -one + c : '0;
      qsw_pkg::ModeScaled:      p = scaled;
      qsw_pkg::ModeMixCos:      p = q1 ? sin2x : q4 ? -sin2x : c;
      qsw_pkg::ModeMixSin4x:    p = q1 ? sin4x : q2 ? -sin2x : s;
      qsw_pkg::ModeSquareEven:  p = q2 ? one : q4 ? -one : s;
      qsw_pkg::ModeSquareOdd:   p = q1 ? one : q3 ? -one : s;
      qsw_pkg::ModeCutMid:      p = (q2 || q3) ? '0 : s;
      qsw_pkg::ModeCutEdge:     p = (q1 || q4) ? '0 : s;
      default:                  p = s;
    endcase

    if (p > qsw_pkg::work_t'(qsw_pkg::OutMax)) begin
      shaped_o = qsw_pkg::OutW'(qsw_pkg::OutMax);
    end else if (p < qsw_pkg::work_t'(qsw_pkg::OutMin)) begin
      shaped_o = qsw_pkg::OutW'(qsw_pkg::OutMin);
    end else begin
      shaped_o = p[qsw_pkg::OutW-1:0];
    end
  end

endmodule

`default_nettype wire
